>>> src/rrst_pkg.sv
// Shared types and constants for the RTCP receiver statistics table.
// No dependencies.
package rrst_pkg;

    localparam int MAX_SOURCES = 64;
    localparam int MAX_REPORTS = 31;
    localparam int IDX_W       = $clog2(MAX_SOURCES);
    localparam int FILL_W      = $clog2(MAX_SOURCES + 1);

    localparam logic [10:0] HDR_BYTES  = 11'd8;
    localparam logic [10:0] SR_BYTES   = 11'd20;
    localparam logic [10:0] RR_BYTES   = 11'd48;
    localparam logic [10:0] BYE_BYTES  = 11'd8;
    localparam logic [10:0] SDES_BYTES = 11'd20;

    typedef enum logic [1:0] {
        OP_DATA   = 2'd0,
        OP_SEND   = 2'd1,
        OP_REPORT = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    // Memory access request from the controller to the entry store
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             wr_addr_en;
        logic             wr_rcv_en;
        logic             wr_rpt_en;
        logic [IDX_W-1:0] wr_idx;
        logic [31:0]      wr_addr;
        logic [31:0]      wr_rcv;
        logic [31:0]      wr_rpt;
    } mem_req_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] rcv;
        logic [31:0] rpt;
    } mem_rsp_t;

endpackage

>>> src/rrst_store.sv
// Source entry store: address, received and reported counts.
// Depends on rrst_pkg. Synchronous read.
module rrst_store
    import rrst_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output mem_rsp_t rsp
);

    logic [31:0] addr_mem [MAX_SOURCES];
    logic [31:0] rcv_mem  [MAX_SOURCES];
    logic [31:0] rpt_mem  [MAX_SOURCES];

    // write ports
    always_ff @(posedge clk)
    begin
        if (req.wr_addr_en)
            addr_mem[req.wr_idx] <= req.wr_addr;
        if (req.wr_rcv_en)
            rcv_mem[req.wr_idx] <= req.wr_rcv;
        if (req.wr_rpt_en)
            rpt_mem[req.wr_idx] <= req.wr_rpt;
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rsp.addr <= addr_mem[req.rd_idx];
            rsp.rcv  <= rcv_mem[req.rd_idx];
            rsp.rpt  <= rpt_mem[req.rd_idx];
        end
    end

endmodule

>>> src/rtcp_receiver_stats_table.sv
// Top level of the RTCP receiver statistics table: controller and store.
// Depends on rrst_pkg and rrst_store.
//
// Each accepted item raises busy until its single result strobes out on
// done. A local-send or unused opcode goes straight to the result. A data
// item scans the stored sources one per cycle through the single read
// port of the entry store. A report walks from newest to oldest one entry
// per cycle with a read-modify-write of the reported count, and ends after
// 31 reports or when all entries are walked. Results cannot be stalled;
// the consumer must take done when it comes.
module rtcp_receiver_stats_table
    import rrst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [31:0] src_addr,
    input  logic        bye,
    output logic        done,
    output logic        status,
    output logic [6:0]  sources_walked,
    output logic [4:0]  reports_made,
    output logic        we_sent,
    output logic [10:0] report_length
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_WALK = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [31:0]       lsent_reg, lsent_next;
    logic [31:0]       llast_reg, llast_next;
    logic [FILL_W-1:0] cnt_reg, cnt_next;     // entries issued
    logic              pend_reg, pend_next;   // read data valid next cycle
    logic [IDX_W-1:0]  pidx_reg, pidx_next;   // index of pending read
    logic [31:0]       key_reg, key_next;
    logic              bye_reg, bye_next;
    logic              hit_reg, hit_next;
    logic [6:0]        walk_reg, walk_next;
    logic [4:0]        made_reg, made_next;
    logic              sent_reg, sent_next;
    logic              stat_reg, stat_next;
    logic              rep_reg, rep_next;

    mem_req_t req;
    mem_rsp_t rsp;

    rrst_store u_store (
        .clk (clk),
        .req (req),
        .rsp (rsp)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        lsent_next = lsent_reg;
        llast_next = llast_reg;
        cnt_next   = cnt_reg;
        pend_next  = 1'b0;
        pidx_next  = pidx_reg;
        key_next   = key_reg;
        bye_next   = bye_reg;
        hit_next   = hit_reg;
        walk_next  = walk_reg;
        made_next  = made_reg;
        sent_next  = sent_reg;
        stat_next  = stat_reg;
        rep_next   = rep_reg;
        req        = '0;
        req.wr_idx = pidx_reg;
        req.wr_addr = key_reg;
        req.wr_rcv = rsp.rcv + 32'd1;
        req.wr_rpt = rsp.rcv;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next  = src_addr;
                    bye_next  = bye;
                    hit_next  = 1'b0;
                    walk_next = '0;
                    made_next = '0;
                    sent_next = 1'b0;
                    stat_next = 1'b0;
                    rep_next  = 1'b0;
                    cnt_next  = '0;
                    case (opcode)
                        OP_DATA:   state_next = S_SCAN;
                        OP_REPORT:
                        begin
                            rep_next = 1'b1;
                            if (lsent_reg != llast_reg)
                            begin
                                sent_next  = 1'b1;
                                llast_next = lsent_reg;
                            end
                            state_next = S_WALK;
                        end
                        OP_SEND:
                        begin
                            lsent_next = lsent_reg + 32'd1;
                            state_next = S_OUT;
                        end
                        default:   state_next = S_OUT;
                    endcase
                end
            end
            S_SCAN:
            begin
                // check the entry read last cycle
                if (pend_reg && rsp.addr == key_reg)
                begin
                    hit_next      = 1'b1;
                    req.wr_rcv_en = 1'b1;
                    state_next    = S_OUT;
                end
                else if (cnt_reg < fill_reg)
                begin
                    req.rd_en  = 1'b1;
                    req.rd_idx = cnt_reg[IDX_W-1:0];
                    pidx_next  = cnt_reg[IDX_W-1:0];
                    pend_next  = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                end
                else
                    state_next = S_FIN;
            end
            S_WALK:
            begin
                // process the entry read last cycle
                if (pend_reg)
                begin
                    walk_next = walk_reg + 7'd1;
                    if (rsp.rcv != rsp.rpt)
                    begin
                        req.wr_rpt_en = 1'b1;
                        made_next     = made_reg + 5'd1;
                    end
                end
                if (pend_reg && rsp.rcv != rsp.rpt
                    && made_reg == 5'(MAX_REPORTS - 1))
                    state_next = S_OUT;
                else if (cnt_reg < fill_reg)
                begin
                    req.rd_en  = 1'b1;
                    req.rd_idx = IDX_W'(fill_reg - cnt_reg - 1'b1);
                    pidx_next  = req.rd_idx;
                    pend_next  = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                end
                else
                    state_next = S_OUT;
            end
            S_FIN:
            begin
                // new source: insert or drop
                if (fill_reg == FILL_W'(MAX_SOURCES))
                    stat_next = 1'b1;
                else
                begin
                    req.wr_idx     = fill_reg[IDX_W-1:0];
                    req.wr_addr_en = 1'b1;
                    req.wr_rcv_en  = 1'b1;
                    req.wr_rpt_en  = 1'b1;
                    req.wr_rcv     = 32'd1;
                    req.wr_rpt     = 32'd0;
                    fill_next      = fill_reg + 1'b1;
                end
                state_next = S_OUT;
            end
            S_OUT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            lsent_reg <= '0;
            llast_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            lsent_reg <= lsent_next;
            llast_reg <= llast_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        pidx_reg <= pidx_next;
        key_reg  <= key_next;
        bye_reg  <= bye_next;
        hit_reg  <= hit_next;
        walk_reg <= walk_next;
        made_reg <= made_next;
        sent_reg <= sent_next;
        stat_reg <= stat_next;
        rep_reg  <= rep_next;
    end

    // result ports
    assign busy           = (state_reg != S_IDLE);
    assign done           = (state_reg == S_OUT);
    assign status         = stat_reg;
    assign sources_walked = walk_reg;
    assign reports_made   = made_reg;
    assign we_sent        = sent_reg;
    assign report_length  = rep_reg
        ? (HDR_BYTES + (sent_reg ? SR_BYTES : 11'd0)
           + 11'(made_reg * RR_BYTES)
           + (bye_reg ? BYE_BYTES : SDES_BYTES))
        : 11'd0;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(MAX_SOURCES))
        else $error("fill exceeds table size");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held more than one cycle");
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> fill_reg == FILL_W'(MAX_SOURCES))
        else $error("drop while table not full");
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |-> $past(state_reg == S_FIN))
        else $error("fill changed outside insert");
`endif

endmodule
